>>> hdl/rme_pkg.sv
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Shared types and register indexes.
// ----------------------------------------------------------------------------
package rme_pkg;
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPONENT = 1'b0,
		REG_MODULUS  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic done;
	} mul_ctl_t;
endpackage

>>> hdl/rme_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a*b mod n by doubling and adding, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rme_mulmod import rme_pkg::*; #(
	parameter int W = 34
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] n,
	output mul_ctl_t     ctl,
	output logic [W-1:0] p
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  acc_q, b_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [W:0]    dbl, dbl_r, sum;
	logic [W-1:0]  d1;

	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
		d1    = dbl_r[W-1:0];
		sum   = {1'b0, d1} + {1'b0, a};
		if (b_q[W-1]) begin
			if (sum >= {1'b0, n})
				sum = sum - {1'b0, n};
		end else begin
			sum = {1'b0, d1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (run_q) begin
			acc_q <= sum[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign ctl.start = run_q;
	assign ctl.done  = done_q;
	assign p         = acc_q;
endmodule

>>> hdl/rsa_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// RSA modular exponentiation
// result_word = message_word ^ exponent mod modulus, square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Write exponent (index 0) and modulus (index 1) on the cfg channel while
//   idle; cfg_ready is always high. Pulse start with message_word when busy
//   is low. One beat in gives one beat out: result_word with done high for
//   exactly one cycle.
// Sequence: first the message is reduced mod modulus, one bit per cycle.
//   Then for each of MOD_BITS exponent bits a square and, for a set bit, a
//   multiply run on the shared bit-serial multiplier.
// Throughput: one item at a time; busy is high from accept until the cycle
//   before done, so the next start can be taken in the done cycle.
// Reset: exponent and modulus return to 1, controller goes idle.
// The receiver cannot stall; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation import rme_pkg::*; #(
	parameter int MOD_BITS = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MOD_BITS-1:0] cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic [MOD_BITS-1:0] message_word,
	output logic                done,
	output logic [MOD_BITS-1:0] result_word
);
	localparam int W  = MOD_BITS;
	localparam int CW = $clog2(W + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RED  = 6'b000010,
		ST_SQ   = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  exp_q, mod_q, base_q, acc_q, e_q, msg_q;
	logic [CW-1:0] cnt_q;
	logic          is_sq_q, mstart;
	logic [W:0]    rem_sh, rem_nx;
	logic [W-1:0]  mul_a, mul_b, mul_p;
	mul_ctl_t      mctl;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= W'(1);
			mod_q <= W'(1);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EXPONENT: exp_q <= cfg_data;
				REG_MODULUS:  mod_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// restoring remainder, one message bit per cycle
	always_comb begin
		rem_sh = {base_q, msg_q[W-1]};
		rem_nx = (rem_sh >= {1'b0, mod_q}) ? rem_sh - {1'b0, mod_q} : rem_sh;
	end

	assign mul_a = is_sq_q ? acc_q : base_q;
	assign mul_b = acc_q;

	rme_mulmod #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.a      (mul_a),
		.b      (mul_b),
		.n      (mod_q),
		.ctl    (mctl),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstart  <= 1'b0;
			done    <= 1'b0;
			cnt_q   <= '0;
			is_sq_q <= 1'b0;
		end else begin
			mstart <= 1'b0;
			done   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RED;
						cnt_q   <= CW'(W);
					end
				end
				ST_RED: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_SQ;
						cnt_q   <= CW'(W);
					end
				end
				ST_SQ: begin
					is_sq_q <= 1'b1;
					mstart  <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_MUL: begin
					is_sq_q <= 1'b0;
					mstart  <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mctl.done) begin
						if (is_sq_q && e_q[W-1]) begin
							state_q <= ST_MUL;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							state_q <= (cnt_q == CW'(1)) ? ST_OUT : ST_SQ;
						end
					end
				end
				ST_OUT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				msg_q  <= message_word;
				base_q <= '0;
				e_q    <= exp_q;
				acc_q  <= (mod_q <= W'(1)) ? '0 : W'(1);
			end
			ST_RED: begin
				base_q <= rem_nx[W-1:0];
				msg_q  <= {msg_q[W-2:0], 1'b0};
			end
			ST_WAIT: begin
				if (mctl.done) begin
					acc_q <= mul_p;
					if (!(is_sq_q && e_q[W-1]))
						e_q <= {e_q[W-2:0], 1'b0};
				end
			end
			ST_OUT: result_word <= acc_q;
			default: ;
		endcase
	end
endmodule
